>>> rtl/k_of_window_event_qualifier_macros.svh
// ----------------------------------------------------------------------------
// k_of_window_event_qualifier_macros
// Assertion macros shared by the qualifier's checker.
// ----------------------------------------------------------------------------
`ifndef K_OF_WINDOW_EVENT_QUALIFIER_MACROS_SVH
`define K_OF_WINDOW_EVENT_QUALIFIER_MACROS_SVH

// same-cycle implication, sampled on clk, off while in reset
`define KOWQ_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kowq: same-cycle property failed");

// next-cycle implication
`define KOWQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kowq: next-cycle property failed");

`endif

>>> rtl/kowq_pkg.sv
// ----------------------------------------------------------------------------
// kowq_pkg
// Shared widths, defaults and command codes of the event qualifier.
// ----------------------------------------------------------------------------
package kowq_pkg;

    localparam int RING_DEPTH_DEF = 128;
    localparam int TS_W           = 32;
    localparam int WIN_W          = 16;
    localparam int REQ_W          = 8;
    localparam int CFG_W          = 16;
    localparam int CFG_IDX_W      = 1;
    localparam int CMD_W          = 2;

    // register indices
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_REQUIRED = 1'b1;

    localparam logic [REQ_W-1:0] REQ_RESET = 8'd1;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD   = 2'd0,
        CMD_CHECK = 2'd1,
        CMD_CLEAR = 2'd2
    } cmd_t;

endpackage

>>> rtl/kowq_ram.sv
// ----------------------------------------------------------------------------
// kowq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module kowq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/k_of_window_event_qualifier.sv
// ----------------------------------------------------------------------------
// k_of_window_event_qualifier
// Sliding time window event counter: k detections within a window.
// ----------------------------------------------------------------------------
// Requests are taken when start is high and busy is low. An add request
// stores its timestamp in the detection ring and a clear request empties the
// ring; both finish in the cycle they are taken and give no result. A check
// request counts stored detections whose time lies in [now - window, now]
// (32-bit wrapping subtraction, unsigned compares) and raises done for one
// cycle with criteria_met. The receiver cannot stall: the result is on the
// ports for exactly that cycle. A check scans the stored entries through the
// single read port of the ring memory, which is read one entry per cycle,
// scores the last read in the drain state and compares the hit count with
// the required count in the result state, whose outcome is registered onto
// done. With a zero window or an empty ring done follows in the next cycle.
// Busy is high from the cycle after acceptance until done is shown, so a
// new request may be taken in the cycle done is shown. The ring needs no
// clearing pass: only entries below the fill count are ever read.
// Configuration writes are taken at any edge with cfg_we high.
// ----------------------------------------------------------------------------
module k_of_window_event_qualifier
    import kowq_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // request channel
    input  logic                 start,
    output logic                 busy,
    input  logic [CMD_W-1:0]     cmd,
    input  logic [TS_W-1:0]      timestamp,
    // result channel
    output logic                 done,
    output logic                 criteria_met,
    // configuration
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_idx,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    localparam int PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CNT_W = $clog2(RING_DEPTH + 1);
    localparam int CMP_W = CNT_W + REQ_W;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_RESULT = 4'b1000
    } state_t;

    state_t             state_reg, state_next;

    // configuration
    logic [WIN_W-1:0]   window_reg;
    logic [REQ_W-1:0]   req_reg;

    // ring bookkeeping
    logic [PTR_W-1:0]   wp_reg, wp_next;
    logic [CNT_W-1:0]   fill_reg, fill_next;

    // scan state
    logic [TS_W-1:0]    now_reg, now_next;
    logic [TS_W-1:0]    lo_reg, lo_next;
    logic [CNT_W-1:0]   issue_reg, issue_next;
    logic [CNT_W-1:0]   hits_reg, hits_next;
    logic               pend_reg, pend_next;
    logic               done_reg, done_next;
    logic               crit_reg, crit_next;

    logic               accept;
    logic               ram_we;
    logic               ram_re;
    logic [TS_W-1:0]    ram_rdata;
    logic [CNT_W-1:0]   issue_inc;
    logic               in_window;
    logic               enough;

    assign accept    = start && (state_reg == ST_IDLE);
    assign busy      = (state_reg != ST_IDLE);
    assign ram_we    = accept && (cmd == CMD_ADD);
    assign ram_re    = (state_reg == ST_SCAN);
    assign issue_inc = issue_reg + CNT_W'(1);

    // entry read last cycle lies inside [lo, now]
    assign in_window = (ram_rdata >= lo_reg) && (ram_rdata <= now_reg);
    assign enough    = {{REQ_W{1'b0}}, hits_reg} >= CMP_W'(req_reg);

    kowq_ram #(
        .WIDTH (TS_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wp_reg),
        .wdata (timestamp),
        .re    (ram_re),
        .raddr (issue_reg[PTR_W-1:0]),
        .rdata (ram_rdata)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
            req_reg    <= REQ_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                REG_WINDOW:   window_reg <= cfg_wdata;
                REG_REQUIRED: req_reg    <= cfg_wdata[REQ_W-1:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        wp_next    = wp_reg;
        fill_next  = fill_reg;
        now_next   = now_reg;
        lo_next    = lo_reg;
        issue_next = issue_reg;
        hits_next  = hits_reg;
        pend_next  = 1'b0;
        done_next  = 1'b0;
        crit_next  = crit_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    priority if (cmd == CMD_ADD)
                    begin
                        // wrap the pointer, saturate the fill count
                        wp_next = (wp_reg == PTR_W'(RING_DEPTH - 1)) ? '0
                                                                    : wp_reg + PTR_W'(1);
                        if (fill_reg != CNT_W'(RING_DEPTH))
                        begin
                            fill_next = fill_reg + CNT_W'(1);
                        end
                    end
                    else if (cmd == CMD_CLEAR)
                    begin
                        wp_next   = '0;
                        fill_next = '0;
                    end
                    else if (cmd == CMD_CHECK)
                    begin
                        now_next   = timestamp;
                        lo_next    = timestamp - TS_W'(window_reg);
                        issue_next = '0;
                        hits_next  = '0;
                        priority if (window_reg == '0)
                        begin
                            // zero window: criteria hold without counting
                            done_next = 1'b1;
                            crit_next = 1'b1;
                        end
                        else if (fill_reg == '0)
                        begin
                            // empty ring: only a zero requirement is met
                            done_next = 1'b1;
                            crit_next = (req_reg == '0);
                        end
                        else
                        begin
                            state_next = ST_SCAN;
                        end
                    end
                    else
                    begin
                        // unused code: ignored
                    end
                end
            end

            ST_SCAN:
            begin
                // one read issued per cycle, its data scored in the next cycle
                pend_next  = 1'b1;
                issue_next = issue_inc;
                if (pend_reg && in_window)
                begin
                    hits_next = hits_reg + CNT_W'(1);
                end
                if (issue_inc == fill_reg)
                begin
                    state_next = ST_DRAIN;
                end
            end

            ST_DRAIN:
            begin
                // last read data
                if (pend_reg && in_window)
                begin
                    hits_next = hits_reg + CNT_W'(1);
                end
                state_next = ST_RESULT;
            end

            ST_RESULT:
            begin
                done_next  = 1'b1;
                crit_next  = enough;
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            wp_reg    <= '0;
            fill_reg  <= '0;
            issue_reg <= '0;
            hits_reg  <= '0;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            wp_reg    <= wp_next;
            fill_reg  <= fill_next;
            issue_reg <= issue_next;
            hits_reg  <= hits_next;
            pend_reg  <= pend_next;
            done_reg  <= done_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        now_reg  <= now_next;
        lo_reg   <= lo_next;
        crit_reg <= crit_next;
    end

    assign done         = done_reg;
    assign criteria_met = crit_reg;

endmodule

>>> rtl/kowq_checker.sv
// ----------------------------------------------------------------------------
// kowq_checker
// Port-level checks of the qualifier's request/result behaviour.
// ----------------------------------------------------------------------------
`include "k_of_window_event_qualifier_macros.svh"

module kowq_checker
    import kowq_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input logic [CMD_W-1:0] cmd,
    input logic             done
);

    logic take_check;
    logic take_other;

    assign take_check = start && !busy && (cmd == CMD_CHECK);
    assign take_other = start && !busy && (cmd != CMD_CHECK);

    // a result only follows a check taken last cycle or the end of a scan
    `KOWQ_ASSERT_NOW(a_done_has_cause, done, $past(take_check) || $past(busy))
    // end of a scan always delivers the result
    `KOWQ_ASSERT_NOW(a_scan_end_done, $fell(busy), done)
    // add, clear and unused codes finish at once and give no result
    `KOWQ_ASSERT_NEXT(a_other_quiet, take_other, !done && !busy)

endmodule

bind k_of_window_event_qualifier kowq_checker u_kowq_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .done  (done)
);
